FILE: rtl/fre_pkg.sv
package fre_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 5;

    localparam int ENTRY_W  = 21;
    localparam int ROW_W    = 3 * ENTRY_W;
    localparam int RAY_W    = COORD_BITS + 23;
    localparam int NORM_W   = 31;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 2;
    localparam int CORD_W   = 36;
    localparam int ANG_W    = 18;
    localparam int TH_W     = 17;
    localparam int PROD_W   = TH_W + NORM_W;
    localparam int NUM_W    = PROD_W + 1;
    localparam int QUO_W    = 18;
    localparam int FOCAL_W  = 10;
    localparam int CTR_W    = 11;
    localparam int OFS_W    = FOCAL_W + TH_W;
    localparam int POS_W    = 30;
    localparam int FIDX_W   = 10;

    localparam int SQRT_STEPS   = RAD_W / 2;
    localparam int CORDIC_STEPS = 16;
    localparam int CSTEP_W      = 4;
    localparam int DIV_STEPS    = QUO_W;

    localparam logic [TH_W-1:0] HALF_PI_Q16 = TH_W'(102944);

    localparam logic [2:0] CFG_INV_ROW_X      = 3'd0;
    localparam logic [2:0] CFG_INV_ROW_Y      = 3'd1;
    localparam logic [2:0] CFG_INV_ROW_W      = 3'd2;
    localparam logic [2:0] CFG_FOCAL_LENGTH   = 3'd3;
    localparam logic [2:0] CFG_FRONT_CENTER_U = 3'd4;
    localparam logic [2:0] CFG_FRONT_CENTER_V = 3'd5;
    localparam logic [2:0] CFG_BACK_CENTER_U  = 3'd6;
    localparam logic [2:0] CFG_BACK_CENTER_V  = 3'd7;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } t_in;

    typedef struct packed {
        logic signed [15:0]  src_u_int;
        logic signed [15:0]  src_v_int;
        logic [FIDX_W-1:0]   frac_index;
        logic                back_lens;
    } t_out;

    typedef struct packed {
        logic              valid;
        logic              back;
        logic              neg_u;
        logic              neg_v;
        logic              rho_zero;
        logic [NORM_W-1:0] ax;
        logic [NORM_W-1:0] ay;
        logic [NORM_W-1:0] aw;
        logic [ROOT_W-1:0] rho;
        logic [TH_W-1:0]   th;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        t_side                    side;
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [ANG_W-1:0]  z;
    } t_cord;

    typedef struct packed {
        t_side             side;
        logic [QUO_W-1:0]  num_u;
        logic [ROOT_W-1:0] rem_u;
        logic [QUO_W-1:0]  quo_u;
        logic [QUO_W-1:0]  num_v;
        logic [ROOT_W-1:0] rem_v;
        logic [QUO_W-1:0]  quo_v;
    } t_div;

    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [CSTEP_W-1:0] step);
        logic signed [ANG_W-1:0] a;
        case (step)
            4'd0:    a = ANG_W'(51472);
            4'd1:    a = ANG_W'(30386);
            4'd2:    a = ANG_W'(16055);
            4'd3:    a = ANG_W'(8150);
            4'd4:    a = ANG_W'(4091);
            4'd5:    a = ANG_W'(2047);
            4'd6:    a = ANG_W'(1024);
            4'd7:    a = ANG_W'(512);
            4'd8:    a = ANG_W'(256);
            4'd9:    a = ANG_W'(128);
            4'd10:   a = ANG_W'(64);
            4'd11:   a = ANG_W'(32);
            4'd12:   a = ANG_W'(16);
            4'd13:   a = ANG_W'(8);
            4'd14:   a = ANG_W'(4);
            default: a = ANG_W'(2);
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/fre_sqrt_cell.sv
module fre_sqrt_cell import fre_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_sqrt i_d,
    output t_sqrt o_d
);

    t_sqrt                r_d;
    t_sqrt                n_d;
    logic [REM_W+1:0]     trial_rem;
    logic [REM_W+1:0]     trial_sub;

    // one root bit per cell: bring down two radicand bits, try 4q+1
    always_comb begin
        n_d       = i_d;
        trial_rem = {i_d.rem, i_d.rad[RAD_W-1 -: 2]};
        trial_sub = (REM_W+2)'({i_d.root, 2'b01});
        n_d.rad   = {i_d.rad[RAD_W-3:0], 2'b00};
        if (trial_rem >= trial_sub) begin
            n_d.rem  = REM_W'(trial_rem - trial_sub);
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = REM_W'(trial_rem);
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.side.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: rtl/fre_cordic_cell.sv
module fre_cordic_cell import fre_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [CSTEP_W-1:0] i_step,
    input  t_cord              i_d,
    output t_cord              o_d
);

    t_cord                    r_d;
    t_cord                    n_d;
    logic signed [CORD_W-1:0] sx;
    logic signed [CORD_W-1:0] sy;

    // vectoring rotation drives cy toward zero
    always_comb begin
        n_d = i_d;
        sx  = i_d.cx >>> i_step;
        sy  = i_d.cy >>> i_step;
        if (!i_d.cy[CORD_W-1]) begin
            n_d.cx = i_d.cx + sy;
            n_d.cy = i_d.cy - sx;
            n_d.z  = i_d.z + atan_q16(i_step);
        end else begin
            n_d.cx = i_d.cx - sy;
            n_d.cy = i_d.cy + sx;
            n_d.z  = i_d.z - atan_q16(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.side.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: rtl/fre_div_cell.sv
module fre_div_cell import fre_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    t_div              r_d;
    t_div              n_d;
    logic [ROOT_W:0]   tu;
    logic [ROOT_W:0]   tv;
    logic [ROOT_W:0]   dd;

    // restoring division, one quotient bit per lane per cell
    always_comb begin
        n_d       = i_d;
        dd        = {1'b0, i_d.side.rho};
        tu        = {i_d.rem_u, i_d.num_u[QUO_W-1]};
        tv        = {i_d.rem_v, i_d.num_v[QUO_W-1]};
        n_d.num_u = {i_d.num_u[QUO_W-2:0], 1'b0};
        n_d.num_v = {i_d.num_v[QUO_W-2:0], 1'b0};
        if (tu >= dd) begin
            n_d.rem_u = ROOT_W'(tu - dd);
            n_d.quo_u = {i_d.quo_u[QUO_W-2:0], 1'b1};
        end else begin
            n_d.rem_u = ROOT_W'(tu);
            n_d.quo_u = {i_d.quo_u[QUO_W-2:0], 1'b0};
        end
        if (tv >= dd) begin
            n_d.rem_v = ROOT_W'(tv - dd);
            n_d.quo_v = {i_d.quo_v[QUO_W-2:0], 1'b1};
        end else begin
            n_d.rem_v = ROOT_W'(tv);
            n_d.quo_v = {i_d.quo_v[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.side.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: rtl/fisheye_remap_coordinate_gen.sv
// pipeline from input transaction to result: 4 front stages, 32 square-root cells,
// 1 normalize stage, 16 cordic cells, 2 product stages, 18 divider cells, 2 output stages
// throughput: one transaction per cycle; the whole pipeline holds while the output stalls
// synchronous active-low reset empties the pipeline and loads the configuration defaults
module fisheye_remap_coordinate_gen import fre_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [ROW_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data
);

    localparam int SH = 16 - FRAC_BITS;

    logic [ROW_W-1:0]   r_inv_x, r_inv_y, r_inv_w;
    logic [FOCAL_W-1:0] r_focal;
    logic [CTR_W-1:0]   r_fcu, r_fcv, r_bcu, r_bcv;

    logic en;

    // stage a: ray
    logic                    r_a_valid;
    logic signed [RAY_W-1:0] r_a_x, r_a_y, r_a_w;
    logic signed [RAY_W-1:0] n_a_x, n_a_y, n_a_w;
    // stage b: magnitudes, c: squares, d: radicand
    t_side                   r_b, n_b;
    t_side                   r_c;
    logic [SQ_W-1:0]         r_c_sx, r_c_sy;
    t_sqrt                   r_d;
    t_cord                   r_e, n_e;
    t_side                   r_f, n_f;
    logic [PROD_W-1:0]       r_f_pu, r_f_pv;
    t_div                    r_g, n_g;
    t_side                   r_h;
    logic [OFS_W-1:0]        r_h_du, r_h_dv;
    t_out                    r_out, n_out;
    logic                    r_out_valid;

    t_sqrt w_sq [0:SQRT_STEPS];
    t_cord w_cd [0:CORDIC_STEPS];
    t_div  w_dv [0:DIV_STEPS];

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x <= ROW_W'(262144);
            r_inv_y <= ROW_W'(262144) << ENTRY_W;
            r_inv_w <= ROW_W'(262144) << (2 * ENTRY_W);
            r_focal <= FOCAL_W'(181);
            r_fcu   <= CTR_W'(320);
            r_fcv   <= CTR_W'(320);
            r_bcu   <= CTR_W'(958);
            r_bcv   <= CTR_W'(320);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_ROW_X:      r_inv_x <= i_cfg_data;
                CFG_INV_ROW_Y:      r_inv_y <= i_cfg_data;
                CFG_INV_ROW_W:      r_inv_w <= i_cfg_data;
                CFG_FOCAL_LENGTH:   r_focal <= i_cfg_data[FOCAL_W-1:0];
                CFG_FRONT_CENTER_U: r_fcu   <= i_cfg_data[CTR_W-1:0];
                CFG_FRONT_CENTER_V: r_fcv   <= i_cfg_data[CTR_W-1:0];
                CFG_BACK_CENTER_U:  r_bcu   <= i_cfg_data[CTR_W-1:0];
                CFG_BACK_CENTER_V:  r_bcv   <= i_cfg_data[CTR_W-1:0];
                default: ;
            endcase
        end
    end

    // stage a: matrix times (col, row, 1)
    logic signed [RAY_W-1:0] cs, rs;
    always_comb begin
        cs    = RAY_W'($signed({1'b0, i_in_data.col}));
        rs    = RAY_W'($signed({1'b0, i_in_data.row}));
        n_a_x = cs * RAY_W'($signed(r_inv_x[ENTRY_W-1:0]))
              + rs * RAY_W'($signed(r_inv_x[2*ENTRY_W-1:ENTRY_W]))
              + RAY_W'($signed(r_inv_x[3*ENTRY_W-1:2*ENTRY_W]));
        n_a_y = cs * RAY_W'($signed(r_inv_y[ENTRY_W-1:0]))
              + rs * RAY_W'($signed(r_inv_y[2*ENTRY_W-1:ENTRY_W]))
              + RAY_W'($signed(r_inv_y[3*ENTRY_W-1:2*ENTRY_W]));
        n_a_w = cs * RAY_W'($signed(r_inv_w[ENTRY_W-1:0]))
              + rs * RAY_W'($signed(r_inv_w[2*ENTRY_W-1:ENTRY_W]))
              + RAY_W'($signed(r_inv_w[3*ENTRY_W-1:2*ENTRY_W]));
    end

    // stage b: magnitudes, shifted down together below 2^31
    logic [RAY_W-1:0] mx, my, mw, mor;
    logic [3:0]       shr;
    always_comb begin
        mx  = r_a_x[RAY_W-1] ? RAY_W'(-r_a_x) : RAY_W'(r_a_x);
        my  = r_a_y[RAY_W-1] ? RAY_W'(-r_a_y) : RAY_W'(r_a_y);
        mw  = r_a_w[RAY_W-1] ? RAY_W'(-r_a_w) : RAY_W'(r_a_w);
        mor = mx | my | mw;
        shr = 4'd0;
        for (int k = NORM_W; k < RAY_W; k++) begin
            if (mor[k]) shr = 4'(k - NORM_W + 1);
        end
        n_b          = '0;
        n_b.valid    = r_a_valid;
        n_b.back     = (r_a_w <= 0);
        n_b.neg_u    = r_a_x[RAY_W-1] != (r_a_w <= 0);
        n_b.neg_v    = r_a_y[RAY_W-1];
        n_b.ax       = NORM_W'(mx >> shr);
        n_b.ay       = NORM_W'(my >> shr);
        n_b.aw       = NORM_W'(mw >> shr);
        n_b.rho_zero = (n_b.ax == '0) && (n_b.ay == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b.valid   <= 1'b0;
            r_c.valid   <= 1'b0;
            r_d.side.valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
            r_a_x     <= n_a_x;
            r_a_y     <= n_a_y;
            r_a_w     <= n_a_w;
            r_b       <= n_b;
            r_c       <= r_b;
            r_c_sx    <= SQ_W'(r_b.ax * r_b.ax);
            r_c_sy    <= SQ_W'(r_b.ay * r_b.ay);
            r_d.side  <= r_c;
            r_d.rad   <= RAD_W'(r_c_sx) + RAD_W'(r_c_sy);
            r_d.rem   <= '0;
            r_d.root  <= '0;
        end
    end

    assign w_sq[0] = r_d;
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        fre_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_sq[g]),
            .o_d     (w_sq[g+1])
        );
    end

    // stage e: scale (|w|, rho) up until the larger reaches 2^30
    logic [ROOT_W-1:0] nor_m;
    logic [4:0]        shl;
    always_comb begin
        n_e      = '0;
        n_e.side = w_sq[SQRT_STEPS].side;
        n_e.side.rho = w_sq[SQRT_STEPS].root;
        nor_m    = ROOT_W'(w_sq[SQRT_STEPS].side.aw) | w_sq[SQRT_STEPS].root;
        shl      = 5'd0;
        for (int k = 0; k < NORM_W - 1; k++) begin
            if (nor_m[k]) shl = 5'(NORM_W - 1 - k);
        end
        if (nor_m[ROOT_W-1] || nor_m[NORM_W-1]) shl = 5'd0;
        n_e.cx = $signed(CORD_W'(w_sq[SQRT_STEPS].side.aw) << shl);
        n_e.cy = $signed(CORD_W'(w_sq[SQRT_STEPS].root) << shl);
        n_e.z  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.side.valid <= 1'b0;
        end else if (en) begin
            r_e <= n_e;
        end
    end

    assign w_cd[0] = r_e;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        fre_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (CSTEP_W'(g)),
            .i_d     (w_cd[g]),
            .o_d     (w_cd[g+1])
        );
    end

    // stage f: clamp angle, scale by |x| and |y|
    logic signed [ANG_W-1:0] zc;
    always_comb begin
        n_f = w_cd[CORDIC_STEPS].side;
        zc  = w_cd[CORDIC_STEPS].z;
        if (zc < 0) begin
            n_f.th = '0;
        end else if (zc > $signed({1'b0, HALF_PI_Q16})) begin
            n_f.th = HALF_PI_Q16;
        end else begin
            n_f.th = TH_W'(zc);
        end
    end

    // stage g: rounded numerators into the divider
    logic [NUM_W-1:0] numu, numv;
    always_comb begin
        numu       = NUM_W'(r_f_pu) + NUM_W'(r_f.rho >> 1);
        numv       = NUM_W'(r_f_pv) + NUM_W'(r_f.rho >> 1);
        n_g        = '0;
        n_g.side   = r_f;
        n_g.rem_u  = ROOT_W'(numu[NUM_W-1:QUO_W]);
        n_g.num_u  = numu[QUO_W-1:0];
        n_g.rem_v  = ROOT_W'(numv[NUM_W-1:QUO_W]);
        n_g.num_v  = numv[QUO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f.valid      <= 1'b0;
            r_g.side.valid <= 1'b0;
        end else if (en) begin
            r_f    <= n_f;
            r_f_pu <= PROD_W'(n_f.th * n_f.ax);
            r_f_pv <= PROD_W'(n_f.th * n_f.ay);
            r_g    <= n_g;
        end
    end

    assign w_dv[0] = r_g;
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        fre_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_dv[g]),
            .o_d     (w_dv[g+1])
        );
    end

    // stage i: center plus offset, round to subpixel grid, saturate
    logic signed [POS_W-1:0] pu, pv, iqu, iqv, ipu, ipv;
    logic [CTR_W-1:0]        cu, cv;
    logic [2*FRAC_BITS-1:0]  fr;
    always_comb begin
        cu = r_h.back ? r_bcu : r_fcu;
        cv = r_h.back ? r_bcv : r_fcv;
        pu = $signed(POS_W'({cu, 16'b0}));
        pv = $signed(POS_W'({cv, 16'b0}));
        if (!r_h.rho_zero) begin
            pu = r_h.neg_u ? pu - $signed(POS_W'(r_h_du)) : pu + $signed(POS_W'(r_h_du));
            pv = r_h.neg_v ? pv - $signed(POS_W'(r_h_dv)) : pv + $signed(POS_W'(r_h_dv));
        end
        iqu = (pu + $signed(POS_W'(1) << (SH - 1))) >>> SH;
        iqv = (pv + $signed(POS_W'(1) << (SH - 1))) >>> SH;
        ipu = iqu >>> FRAC_BITS;
        ipv = iqv >>> FRAC_BITS;
        n_out = '0;
        if (ipu > $signed(POS_W'(32767)))       n_out.src_u_int = 16'sh7FFF;
        else if (ipu < -$signed(POS_W'(32768))) n_out.src_u_int = -16'sh8000;
        else                                    n_out.src_u_int = 16'(ipu);
        if (ipv > $signed(POS_W'(32767)))       n_out.src_v_int = 16'sh7FFF;
        else if (ipv < -$signed(POS_W'(32768))) n_out.src_v_int = -16'sh8000;
        else                                    n_out.src_v_int = 16'(ipv);
        fr               = {iqv[FRAC_BITS-1:0], iqu[FRAC_BITS-1:0]};
        n_out.frac_index = FIDX_W'(fr);
        n_out.back_lens  = r_h.back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h.valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_h         <= w_dv[DIV_STEPS].side;
            r_h_du      <= OFS_W'(r_focal * w_dv[DIV_STEPS].quo_u[TH_W-1:0]);
            r_h_dv      <= OFS_W'(r_focal * w_dv[DIV_STEPS].quo_v[TH_W-1:0]);
            r_out_valid <= r_h.valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
